[rtl/lrgd_pkg.sv]
// Shared types and constants of the line-fit gradient descent block.
`timescale 1ns / 1ps
package lrgd_pkg;

  localparam int SMP_W     = 16;
  localparam int COEF_W    = 32;
  localparam int COST_W    = 48;
  localparam int IDX_W     = 6;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int ITER_W    = 7;
  localparam int MAX_RUNS  = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE  = 2'd0,
    CFG_ITER  = 2'd1,
    CFG_ICPT  = 2'd2,
    CFG_SLOPE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/lrgd_if.sv]
// Channel interfaces: sample pairs in, per-iteration results out.
`timescale 1ns / 1ps
interface lrgd_in_if import lrgd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] x_sample;
  logic [SMP_W-1:0] y_sample;
  logic             last_sample;

  modport source (output valid, x_sample, y_sample, last_sample, input ready);
  modport sink   (input valid, x_sample, y_sample, last_sample, output ready);
endinterface

interface lrgd_out_if import lrgd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         iteration_index;
  logic signed [COEF_W-1:0] intercept_out;
  logic signed [COEF_W-1:0] slope_out;
  logic [COST_W-1:0]        cost_out;
  logic                     last_result;
  logic                     overflow_flag;

  modport source (output valid, iteration_index, intercept_out, slope_out, cost_out,
                  last_result, overflow_flag, input ready);
  modport sink   (input valid, iteration_index, intercept_out, slope_out, cost_out,
                  last_result, overflow_flag, output ready);
endinterface

[rtl/lrgd_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lrgd_div import lrgd_pkg::*; #(
  parameter int DW = 61,
  parameter int VW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output div_stat_t     stat
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dq;
  logic [VW-1:0]    rem;
  logic [VW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             ge;

  assign trial = {rem, dq[DW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dq   <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
        dq  <= {dq[DW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = dq;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[rtl/linear_regression_gradient_descent.sv]
// Top level: sample store, residual pipeline and descent sequencer.
//
//  port    | dir  | moves
//  --------+------+---------------------------------------------------------
//  sample  | in   | one (x, y, last) pair per transfer
//  result  | out  | one (index, intercept, slope, cost, last, overflow) per iteration
//  cfg_*   | in   | register write, index 0..3, one per cycle
//
// Pairs are taken while the block is in its load state. After the last pair each
// iteration makes two sweeps of the store (one read per cycle) and runs the intercept,
// slope and cost divisions in the shared serial divider, DW = 61.
// rst is synchronous; the store itself is not cleared.
// A stalled result holds the next iteration at its end; samples are taken again
// once the final result sits in the output register.
`timescale 1ns / 1ps
module linear_regression_gradient_descent import lrgd_pkg::*; #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  lrgd_in_if.sink              sample,
  lrgd_out_if.source           result
);

  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int RW  = 41;            // residual
  localparam int RXW = 57;            // residual * x
  localparam int IW  = RW + CW;       // intercept sum
  localparam int SW  = 49 + CW;       // slope sum
  localparam int MW  = SW;            // magnitude of a sum
  localparam int DW  = (MW > 61) ? MW : 61;
  localparam int VW  = CW + 1;
  localparam int ACW = 61;            // cost accumulator, capped at 2^60

  typedef enum logic [3:0] {
    S_LOAD, S_ISSUE, S_DRAIN, S_MAG, S_MUL, S_SUM, S_DIV_GO, S_DIV_WAIT, S_APPLY, S_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [CFG_W-1:0]         lr_rate;
  logic [ITER_W-1:0]        iter_cfg;
  logic signed [COEF_W-1:0] icpt_init;
  logic signed [COEF_W-1:0] slope_init;

  always_ff @(posedge clk) begin
    if (rst) begin
      lr_rate    <= CFG_W'(42950);
      iter_cfg   <= ITER_W'(20);
      icpt_init  <= '0;
      slope_init <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RATE:  lr_rate    <= cfg_data;
        CFG_ITER:  iter_cfg   <= cfg_data[ITER_W-1:0];
        CFG_ICPT:  icpt_init  <= cfg_data;
        CFG_SLOPE: slope_init <= cfg_data;
      endcase
    end
  end

  // sample store
  logic [2*SMP_W-1:0] mem [MAX_SAMPLES];
  logic [2*SMP_W-1:0] mem_q;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      run_cnt;
  logic [CW-1:0]      idx;
  logic               in_xfer;
  logic               store_wr;

  assign sample.ready = (state == S_LOAD);
  assign in_xfer      = sample.valid && sample.ready;
  assign store_wr     = in_xfer && (cnt < CW'(MAX_SAMPLES));

  always_ff @(posedge clk) begin
    if (store_wr) begin
      mem[cnt[AW-1:0]] <= {sample.x_sample, sample.y_sample};
    end
    mem_q <= mem[idx[AW-1:0]];
  end

  // coefficients and sums
  logic signed [COEF_W-1:0] intercept;
  logic signed [COEF_W-1:0] slope;
  logic signed [IW-1:0]     isum;
  logic signed [SW-1:0]     ssum;
  logic [ACW-1:0]           acc;
  logic                     cost_pass;

  // residual pipeline
  logic                     v1, v2, v3, v4, v5, v6;
  logic [SMP_W-1:0]         x2, y2, x3, y3, x4;
  logic signed [47:0]       p;
  logic signed [48:0]       p_full;
  logic signed [RW-1:0]     r;
  logic signed [RW-1:0]     r_next;
  logic signed [RXW:0]      rx_full;
  logic signed [RXW-1:0]    rx;
  logic [RW-1:0]            m;
  logic                     cap;
  logic [43:0]              aa;
  logic [37:0]              ab;
  logic [31:0]              bb;
  logic [ACW-1:0]           term;
  logic [ACW:0]             acc_sum;

  assign p_full  = slope * $signed({1'b0, x2});
  assign r_next  = $signed({{9{intercept[31]}}, intercept}) + $signed({p[47], p[47:8]})
                 - $signed({17'b0, y3, 8'b0});
  assign rx_full = r * $signed({1'b0, x4});
  assign m       = r[RW-1] ? (~r + 1'b1) : r;
  assign acc_sum = {1'b0, acc} + {1'b0, term};

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6} <= '0;
    end else begin
      v1 <= (state == S_ISSUE);
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5 && cost_pass;
    end
    x2 <= mem_q[2*SMP_W-1:SMP_W];
    y2 <= mem_q[SMP_W-1:0];
    p  <= p_full[47:0];
    x3 <= x2;
    y3 <= y2;
    r  <= r_next;
    x4 <= x3;
    rx <= rx_full[RXW-1:0];
    cap <= |m[RW-1:38];
    aa <= m[37:16] * m[37:16];
    ab <= m[37:16] * m[15:0];
    bb <= m[15:0] * m[15:0];
    term <= cap ? (ACW'(1) << 60)
                : (ACW'({aa, 16'b0}) + ACW'({ab, 1'b0}) + ACW'(bb[31:16]));
  end

  // step scaling
  logic [MW-1:0]   mag;
  logic            neg;
  logic [MW-1:0]   prod_hi;
  logic [63:0]     prod_lo;
  logic [MW-1:0]   prod_hi_full;
  logic [DW-1:0]   div_a;
  logic [VW-1:0]   div_b;
  logic            div_start;
  logic [DW-1:0]   div_q;
  div_stat_t       dstat;
  logic            slope_phase;
  logic signed [MW+1:0] coef_ext;
  logic signed [MW+1:0] upd;
  logic signed [COEF_W-1:0] upd_sat;
  logic            upd_ovf;
  logic [MW-1:0]   mag_next;

  assign prod_hi_full = mag[MW-1:32] * MW'(lr_rate);
  assign mag_next = slope_phase ? (ssum[SW-1] ? MW'(-ssum) : MW'(ssum))
                                : (isum[IW-1] ? MW'(-isum) : MW'(isum));
  assign coef_ext = slope_phase ? (MW+2)'(slope) : (MW+2)'(intercept);
  assign upd      = neg ? coef_ext + $signed({2'b0, div_q[MW-1:0]})
                        : coef_ext - $signed({2'b0, div_q[MW-1:0]});

  always_comb begin
    upd_ovf = 1'b1;
    if (upd > (MW+2)'(32'sh7FFF_FFFF)) begin
      upd_sat = 32'sh7FFF_FFFF;
    end else if (upd < -(MW+2)'(33'sh0_8000_0000)) begin
      upd_sat = 32'sh8000_0000;
    end else begin
      upd_sat = upd[COEF_W-1:0];
      upd_ovf = 1'b0;
    end
  end

  lrgd_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_q),
    .stat     (dstat)
  );

  // sequencer
  logic [IDX_W-1:0] iter;
  logic [IDX_W-1:0] runs_m1;
  logic             run_drop;
  logic             dropped;
  logic             sat;
  logic             res_load;
  logic             cost_sat;
  logic             pipe_busy;

  assign runs_m1   = (iter_cfg == '0) ? '0 :
                     (iter_cfg > ITER_W'(MAX_RUNS)) ? IDX_W'(MAX_RUNS - 1)
                                                    : IDX_W'(iter_cfg - 1'b1);
  assign pipe_busy = v1 | v2 | v3 | v4 | v5 | v6;
  assign div_start = (state == S_DIV_GO);
  assign res_load  = (state == S_EMIT) && (!result.valid || result.ready);
  assign cost_sat  = |div_q[DW-1:COST_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      cnt          <= '0;
      dropped      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && !res_load) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (sample.last_sample) begin
              run_cnt   <= store_wr ? cnt + 1'b1 : cnt;
              run_drop  <= dropped || !store_wr;
              cnt       <= '0;
              dropped   <= 1'b0;
              intercept <= icpt_init;
              slope     <= slope_init;
              iter      <= '0;
              sat       <= 1'b0;
              cost_pass <= 1'b0;
              isum      <= '0;
              ssum      <= '0;
              idx       <= '0;
              state     <= S_ISSUE;
            end else if (store_wr) begin
              cnt <= cnt + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        S_ISSUE: begin
          idx <= idx + 1'b1;
          if (idx + 1'b1 >= run_cnt) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!pipe_busy) begin
            if (cost_pass) begin
              div_a <= DW'(acc);
              div_b <= {run_cnt, 1'b0};
              state <= S_DIV_GO;
            end else begin
              slope_phase <= 1'b0;
              state       <= S_MAG;
            end
          end
        end
        S_MAG: begin
          mag   <= mag_next;
          neg   <= slope_phase ? ssum[SW-1] : isum[IW-1];
          state <= S_MUL;
        end
        S_MUL: begin
          prod_hi <= prod_hi_full;
          prod_lo <= mag[31:0] * lr_rate;
          state   <= S_SUM;
        end
        S_SUM: begin
          div_a <= DW'(prod_hi + MW'(prod_lo[63:32]));
          div_b <= {1'b0, run_cnt};
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (dstat.done) begin
            state <= cost_pass ? S_EMIT : S_APPLY;
          end
        end
        S_APPLY: begin
          sat <= sat | upd_ovf;
          if (!slope_phase) begin
            intercept   <= upd_sat;
            slope_phase <= 1'b1;
            state       <= S_MAG;
          end else begin
            slope     <= upd_sat;
            cost_pass <= 1'b1;
            acc       <= '0;
            idx       <= '0;
            state     <= S_ISSUE;
          end
        end
        S_EMIT: begin
          if (res_load) begin
            result.valid           <= 1'b1;
            result.iteration_index <= iter;
            result.intercept_out   <= intercept;
            result.slope_out       <= slope;
            result.cost_out        <= cost_sat ? {COST_W{1'b1}} : div_q[COST_W-1:0];
            result.last_result     <= (iter == runs_m1);
            result.overflow_flag   <= run_drop | sat | cost_sat;
            sat                    <= sat | cost_sat;
            iter                   <= iter + 1'b1;
            if (iter == runs_m1) begin
              state <= S_LOAD;
            end else begin
              cost_pass <= 1'b0;
              isum      <= '0;
              ssum      <= '0;
              idx       <= '0;
              state     <= S_ISSUE;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
      // accumulate residual terms as they leave the pipeline
      if (v4 && !cost_pass) begin
        isum <= isum + IW'(r);
      end
      if (v5 && !cost_pass) begin
        ssum <= ssum + SW'($signed(rx[RXW-1:8]));
      end
      if (v6) begin
        acc <= (acc_sum > (ACW+1)'(1) << 60) ? (ACW'(1) << 60) : acc_sum[ACW-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_pipe_idle_in_load: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |-> !pipe_busy)
    else $error("residual pipeline active while loading");

  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !dstat.busy)
    else $error("divider restarted while busy");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (res_load && iter == runs_m1) |=> (state == S_LOAD && result.last_result))
    else $error("final result did not end the run");
`endif

endmodule

[tb/tb.sv]
// Testbench of the line-fit gradient descent block with a fixed-point fit predictor.
`timescale 1ns / 1ps
module tb;
  import lrgd_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int SETTLE      = 400;
  localparam int CYCLE_LIMIT = 50000000;
  localparam longint unsigned COST_CAP = 64'd1 << 60;
  localparam longint unsigned COST_MAX = (64'd1 << 48) - 1;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [COEF_W-1:0] icpt;
    logic [COEF_W-1:0] slp;
    logic [COST_W-1:0] cost;
    logic              lst;
    logic              ovf;
  } fit_result_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  lrgd_in_if  sample ();
  lrgd_out_if result ();

  linear_regression_gradient_descent dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample.sink),
    .result    (result.source)
  );

  // register mirror
  logic [31:0]      rate_reg;
  logic [ITER_W-1:0] iter_reg;
  int               icpt_init_reg;
  int               slope_init_reg;

  // samples of the data set being loaded
  logic [15:0] set_x [STORE_DEPTH];
  logic [15:0] set_y [STORE_DEPTH];
  int          set_n;
  bit          set_dropped;

  fit_result_t fit_q[$];
  int errors;
  int pairs_sent;
  int runs_seen;
  int results_checked;
  int rx_hold;
  bit quiet;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint residual(int icpt, int slp, logic [15:0] x, logic [15:0] y);
    longint p;
    p = longint'(slp) * longint'({48'd0, x});
    return longint'(icpt) + (p >>> 8) - longint'({48'd0, y} << 8);
  endfunction

  // truncate toward zero: sign(sum) * floor(floor(|sum| * rate / 2^32) / n)
  function automatic longint scaled_step(longint s, int n);
    longint unsigned mag, q, r64;
    r64 = {32'd0, rate_reg};
    mag = (s < 0) ? longint'(-s) : longint'(s);
    q = (mag >> 32) * r64 + (((mag & 64'hFFFF_FFFF) * r64) >> 32);
    q = q / longint'(n);
    return (s < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned square_q16(longint r);
    longint unsigned m, a, b;
    m = (r < 0) ? longint'(-r) : longint'(r);
    if (m >= (64'd1 << 38)) return COST_CAP;
    a = m >> 16;
    b = m & 64'hFFFF;
    return ((a * a) << 16) + 2 * a * b + ((b * b) >> 16);
  endfunction

  function automatic int sat_coef(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return int'(v);
  endfunction

  // store one pair; on the marked pair, push every iteration's result
  task automatic predict_pair(logic [15:0] x, logic [15:0] y, bit last);
    int runs, n, icpt, slp;
    longint isum, ssum, r;
    longint unsigned cacc, cost;
    bit sat;
    fit_result_t e;
    if (set_n < STORE_DEPTH) begin
      set_x[set_n] = x;
      set_y[set_n] = y;
      set_n++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return;
    n = (set_n == 0) ? 1 : set_n;
    runs = (iter_reg == 0) ? 1 : ((iter_reg > MAX_RUNS) ? MAX_RUNS : int'(iter_reg));
    icpt = icpt_init_reg;
    slp = slope_init_reg;
    sat = 1'b0;
    for (int it = 0; it < runs; it++) begin
      isum = 0;
      ssum = 0;
      for (int i = 0; i < set_n; i++) begin
        r = residual(icpt, slp, set_x[i], set_y[i]);
        isum += r;
        ssum += (r * longint'({48'd0, set_x[i]})) >>> 8;
      end
      icpt = sat_coef(longint'(icpt) - scaled_step(isum, n), sat);
      slp = sat_coef(longint'(slp) - scaled_step(ssum, n), sat);
      cacc = 0;
      for (int i = 0; i < set_n; i++) begin
        cacc += square_q16(residual(icpt, slp, set_x[i], set_y[i]));
        if (cacc > COST_CAP) cacc = COST_CAP;
      end
      cost = cacc / (2 * longint'(n));
      if (cost > COST_MAX) begin
        cost = COST_MAX;
        sat = 1'b1;
      end
      e.idx = it[IDX_W-1:0];
      e.icpt = icpt;
      e.slp = slp;
      e.cost = cost[COST_W-1:0];
      e.lst = (it + 1 == runs);
      e.ovf = set_dropped || sat;
      fit_q.push_back(e);
    end
    set_n = 0;
    set_dropped = 1'b0;
    runs_seen++;
  endtask

  function automatic int draw_gap();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_pair(logic [15:0] x, logic [15:0] y, bit last);
    int gap;
    sample.valid <= 1'b1;
    sample.x_sample <= x;
    sample.y_sample <= y;
    sample.last_sample <= last;
    do @(posedge clk); while (!sample.ready);
    pairs_sent++;
    predict_pair(x, y, last);
    gap = draw_gap();
    if (gap > 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    sample.valid <= 1'b0;
    while (fit_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write all four registers on consecutive edges, block idle
  task automatic set_regs(logic [31:0] rate, logic [31:0] iters, logic [31:0] icpt,
                          logic [31:0] slp);
    logic [31:0] vals [4];
    vals = '{rate, iters, icpt, slp};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    rate_reg = rate;
    iter_reg = iters[ITER_W-1:0];
    icpt_init_reg = icpt;
    slope_init_reg = slp;
  endtask

  function automatic logic [15:0] rand_field();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'h0000;
    if (p == 1) return 16'hFFFF;
    if (p < 5) return 16'($urandom_range(0, 16'h0800));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic send_set(int n);
    for (int i = 0; i < n; i++) send_pair(rand_field(), rand_field(), i == n - 1);
  endtask

  task automatic test_reset_defaults();
    send_pair(16'h0100, 16'h0200, 1'b1);
    send_set(3);
    drain();
  endtask

  task automatic test_field_extremes();
    set_regs(32'd42950, 32'd5, 32'd0, 32'd0);
    send_pair(16'hFFFF, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'hFFFF, 1'b0);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1);
    drain();
    // huge rate and extreme starting point: coefficients and cost saturate
    set_regs(32'hFFFF_FFFF, 32'd3, 32'h7FFF_FFFF, 32'h8000_0000);
    send_pair(16'hFFFF, 16'h0000, 1'b0);
    send_pair(16'h8000, 16'hFFFF, 1'b1);
    drain();
    set_regs(32'd0, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_pair(16'hFFFF, 16'h1234, 1'b1);
    drain();
  endtask

  task automatic test_iteration_bounds();
    set_regs(32'd200000, 32'd0, 32'h0001_0000, 32'hFFFF_0000);
    send_set(2);
    drain();
    set_regs(32'd200000, 32'd127, 32'd0, 32'd0);
    send_set(2);
    drain();
    set_regs(32'd100000, 32'd64, 32'h0000_8000, 32'd0);
    send_set(1);
    drain();
  endtask

  task automatic test_store_overflow();
    set_regs(32'd42950, 32'd2, 32'd0, 32'd0);
    send_set(STORE_DEPTH);
    // two extra pairs: both dropped, the marked one still starts the run
    send_set(STORE_DEPTH + 2);
    drain();
  endtask

  task automatic test_backpressure();
    set_regs(32'd300000, 32'd6, 32'd0, 32'd0);
    rx_hold = 2000;
    quiet = 1'b1;
    for (int s = 0; s < 4; s++) send_set(3);
    quiet = 1'b0;
    // pause until every result has come back
    drain();
  endtask

  task automatic test_random_sets();
    int p, n;
    logic [31:0] rate, iters, icpt, slp;
    while (pairs_sent < 480) begin
      drain();
      p = $urandom_range(0, 3);
      rate = (p == 0) ? $urandom() : ((p == 1) ? 32'hFFFF_FFFF : $urandom_range(0, 400000));
      p = $urandom_range(0, 19);
      iters = (p == 0) ? 32'd0 : ((p == 1) ? 32'd64 : ((p == 2) ? $urandom_range(65, 127)
              : $urandom_range(1, 8)));
      icpt = $urandom_range(0, 1) ? $urandom() : 32'($signed($urandom_range(0, 20'hFFFFF))
             - 32'sh80000);
      slp = $urandom_range(0, 1) ? $urandom() : 32'($signed($urandom_range(0, 20'hFFFFF))
            - 32'sh80000);
      set_regs(rate, iters, icpt, slp);
      quiet = ($urandom_range(0, 4) == 0);
      for (int s = 0; s < 4; s++) begin
        p = $urandom_range(0, 29);
        n = (p == 0) ? $urandom_range(STORE_DEPTH, STORE_DEPTH + 4)
            : ((p == 1) ? $urandom_range(9, 40) : $urandom_range(1, 8));
        send_set(n);
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_RATE;
    cfg_data = '0;
    sample.valid = 1'b0;
    sample.x_sample = '0;
    sample.y_sample = '0;
    sample.last_sample = 1'b0;
    rate_reg = 32'd42950;
    iter_reg = 7'd20;
    icpt_init_reg = 0;
    slope_init_reg = 0;
    set_n = 0;
    set_dropped = 1'b0;
    errors = 0;
    pairs_sent = 0;
    runs_seen = 0;
    results_checked = 0;
    rx_hold = 0;
    quiet = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_field_extremes();
    test_iteration_bounds();
    test_store_overflow();
    test_backpressure();
    test_random_sets();
    drain();
    $display("Sent %0d sample pairs in %0d fit runs; checked %0d iteration results.",
             pairs_sent, runs_seen, results_checked);
    $display("Covered register extremes, iteration bounds, store overflow and backpressure.");
    if (errors == 0) begin
      $display("linear_regression_gradient_descent: match");
    end else begin
      $display("linear_regression_gradient_descent: mismatch");
    end
    $finish;
  end

  // result ready: random gaps, quiet stretches, and a long counted hold on request
  initial begin
    int gap;
    gap = 0;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        result.ready <= 1'b0;
        rx_hold--;
      end else if (gap > 0) begin
        result.ready <= 1'b0;
        gap--;
      end else begin
        result.ready <= 1'b1;
        gap = draw_gap();
      end
    end
  end

  always @(posedge clk) begin
    fit_result_t e;
    if (!rst && result.valid && result.ready) begin
      if (fit_q.size() == 0) begin
        $error("unexpected result transfer, index %0d", result.iteration_index);
        errors++;
      end else begin
        e = fit_q.pop_front();
        results_checked++;
        if (result.iteration_index !== e.idx) begin
          $error("iteration_index: expected %0d, got %0d", e.idx, result.iteration_index);
          errors++;
        end
        if (result.intercept_out !== e.icpt) begin
          $error("intercept_out: expected %h, got %h", e.icpt, result.intercept_out);
          errors++;
        end
        if (result.slope_out !== e.slp) begin
          $error("slope_out: expected %h, got %h", e.slp, result.slope_out);
          errors++;
        end
        if (result.cost_out !== e.cost) begin
          $error("cost_out: expected %h, got %h", e.cost, result.cost_out);
          errors++;
        end
        if (result.last_result !== e.lst) begin
          $error("last_result: expected %b, got %b", e.lst, result.last_result);
          errors++;
        end
        if (result.overflow_flag !== e.ovf) begin
          $error("overflow_flag: expected %b, got %b", e.ovf, result.overflow_flag);
          errors++;
        end
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d results pending.", cycles, fit_q.size());
        $display("linear_regression_gradient_descent: mismatch");
        $finish;
      end
    end
  end

endmodule
